// ----- sv/rfq_pkg.sv -----
package rfq_pkg;

    // Largest number of results that a single dump reports.
    localparam int MAX_RESULTS = 16;

    // Command codes carried on the input channel.
    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_DUMP    = 2'd2,
        CMD_REVERSE = 2'd3
    } t_cmd;

    // Status codes carried on the output channel.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

endpackage

// ----- sv/rfq_ram.sv -----
module rfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/rfq_slot_unit.sv -----
module rfq_slot_unit #(
    parameter int DEPTH = 16
) (
    input  logic [$clog2(DEPTH)-1:0] i_head,
    input  logic [$clog2(DEPTH)-1:0] i_pos,
    input  logic                     i_backward,
    output logic [$clog2(DEPTH)-1:0] o_slot
);

    localparam int AW = $clog2(DEPTH);

    logic [AW:0] w_sum;
    logic [AW:0] w_wrap;

    // Physical slot of a queue position: head plus or minus the position,
    // folded back into the ring with one compare and one correction.
    always_comb begin
        w_sum  = {1'b0, i_head} + {1'b0, i_pos};
        w_wrap = {1'b0, i_head} + (AW+1)'(DEPTH) - {1'b0, i_pos};
        if (i_backward) begin
            if (i_head >= i_pos) begin
                o_slot = i_head - i_pos;
            end else begin
                o_slot = w_wrap[AW-1:0];
            end
        end else begin
            if (w_sum >= (AW+1)'(DEPTH)) begin
                o_slot = AW'(w_sum - (AW+1)'(DEPTH));
            end else begin
                o_slot = w_sum[AW-1:0];
            end
        end
    end

endmodule

// ----- sv/reversible_fifo_queue.sv -----
// Channel   Direction  Handshake           Payload
// command   in         i_valid / o_stall   i_cmd, i_value
// result    out        o_valid / i_stall   o_word, o_status, o_last
//
// One command at a time; o_stall is high from acceptance until the final
// result is taken. Push, reverse, and a pop or dump of an empty queue go
// straight to the result; any other pop, and each entry that a dump reports,
// passes through the registered store read first. Synchronous reset
// empties the queue. A result-side stall holds the result.
module reversible_fifo_queue
    import rfq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_word,
    output logic [1:0]         o_status,
    output logic               o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DumpMax = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_fill, n_fill;
    logic               r_backward, n_backward;
    logic               r_dump, n_dump;
    logic [AW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic signed [31:0] r_word, n_word;
    t_status            r_status, n_status;
    logic               r_last, n_last;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    t_cmd               w_cmd;
    logic [AW-1:0]      w_slot_pos;
    logic [AW-1:0]      w_slot;
    logic               w_we;
    logic [AW-1:0]      w_raddr;
    logic [31:0]        w_rdata;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_full   = (r_fill == CW'(DEPTH));
    assign w_empty  = (r_fill == '0);
    assign w_cmd    = t_cmd'(i_cmd);

    // Shared slot-address unit.
    rfq_slot_unit #(
        .DEPTH (DEPTH)
    ) u_slot (
        .i_head     (r_head),
        .i_pos      (w_slot_pos),
        .i_backward (r_backward),
        .o_slot     (w_slot)
    );

    // Queue storage.
    rfq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata (i_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((w_cmd == CMD_POP || w_cmd == CMD_DUMP) && !w_empty) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stall) begin
                    if (r_dump && !r_last) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Operand selection for the slot unit and the store ports.
    always_comb begin
        w_slot_pos = r_pos + AW'(1);
        w_raddr    = r_head;
        w_we       = 1'b0;
        case (r_state)
            S_IDLE: begin
                case (w_cmd)
                    CMD_PUSH: begin
                        w_slot_pos = r_fill[AW-1:0];
                        w_we       = w_accept && !w_full;
                    end
                    CMD_POP: begin
                        w_slot_pos = AW'(1);
                    end
                    CMD_REVERSE: begin
                        w_slot_pos = AW'(r_fill - CW'(1));
                    end
                    default: begin
                        w_slot_pos = '0;
                    end
                endcase
            end
            S_EMIT: begin
                w_raddr = w_slot;
            end
            default: begin
                w_raddr = r_head;
            end
        endcase
    end

    // Queue state and result register updates.
    always_comb begin
        n_head     = r_head;
        n_fill     = r_fill;
        n_backward = r_backward;
        n_dump     = r_dump;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_word     = r_word;
        n_status   = r_status;
        n_last     = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_word   = '0;
                    n_status = STATUS_OK;
                    n_last   = 1'b1;
                    n_dump   = 1'b0;
                    case (w_cmd)
                        CMD_PUSH: begin
                            if (w_full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                n_fill = r_fill + CW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (w_empty) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                n_head = w_slot;
                                n_fill = r_fill - CW'(1);
                            end
                        end
                        CMD_DUMP: begin
                            if (w_empty) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                n_dump = 1'b1;
                                n_pos  = '0;
                                if (r_fill > CW'(DumpMax)) begin
                                    n_cnt = CW'(DumpMax);
                                end else begin
                                    n_cnt = r_fill;
                                end
                            end
                        end
                        CMD_REVERSE: begin
                            if (r_fill >= CW'(2)) begin
                                n_head     = w_slot;
                                n_backward = !r_backward;
                            end
                        end
                        default: begin
                            n_status = STATUS_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_word   = w_rdata;
                n_status = STATUS_OK;
                if (r_dump) begin
                    n_last = ((CW'(r_pos) + CW'(1)) == r_cnt);
                end else begin
                    n_last = 1'b1;
                end
            end
            S_EMIT: begin
                if (!i_stall && r_dump && !r_last) begin
                    n_pos = r_pos + AW'(1);
                end
            end
            default: begin
                n_last = 1'b1;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_fill     <= '0;
            r_backward <= 1'b0;
            r_dump     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_fill     <= n_fill;
            r_backward <= n_backward;
            r_dump     <= n_dump;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_cnt    <= n_cnt;
        r_word   <= n_word;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_EMIT);
    assign o_word   = r_word;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule
